>>> hw/rtl/vdp_pkg.sv
`default_nettype none

package vdp_pkg;

    localparam int ADDR_W = 14;
    localparam int BYTE_W = 8;
    localparam int CIDX_W = 6;

    localparam int VRAM_DEPTH_DEF = 16384;
    localparam int CRAM_DEPTH_DEF = 64;
    localparam int REG_COUNT_DEF  = 16;

    localparam logic [2:0] REQ_CTRL_WR   = 3'd0;
    localparam logic [2:0] REQ_STATUS_RD = 3'd1;
    localparam logic [2:0] REQ_DATA_WR   = 3'd2;
    localparam logic [2:0] REQ_DATA_RD   = 3'd3;
    localparam logic [2:0] REQ_FLAGS_SET = 3'd4;

    localparam logic [1:0] MODE_VRAM_RD = 2'd0;
    localparam logic [1:0] MODE_REG_WR  = 2'd2;
    localparam logic [1:0] MODE_CRAM_WR = 2'd3;

    localparam logic [CIDX_W-1:0] CRAM_MASK_PAIR   = 6'h3f;
    localparam logic [CIDX_W-1:0] CRAM_MASK_SINGLE = 6'h1f;
    localparam logic [BYTE_W-1:0] STATUS_KEEP_MASK = 8'h3f;

endpackage

`default_nettype wire

>>> hw/rtl/vdp_ram.sv
`default_nettype none

module vdp_ram #(
    parameter int DEPTH = vdp_pkg::VRAM_DEPTH_DEF,
    parameter int WIDTH = vdp_pkg::BYTE_W
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/vdp_port_interface.sv
// The result strobe (done) is registered from the execute state that follows the
// accepting edge. A new transaction is taken only while busy is low: the synchronous
// VRAM read is followed by the modify and write-back step, and a handheld odd color
// write adds a paired write state. Reset: control registers clear at once, then a
// clearing pass zeroes VRAM and color RAM with busy high; configuration writes are
// taken throughout. The receiver cannot stall: each result is a one-cycle strobe on done.
`default_nettype none

module vdp_port_interface #(
    parameter int VRAM_DEPTH = vdp_pkg::VRAM_DEPTH_DEF,
    parameter int CRAM_DEPTH = vdp_pkg::CRAM_DEPTH_DEF,
    parameter int REG_COUNT  = vdp_pkg::REG_COUNT_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_wdata,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [2:0]                  req_type,
    input  wire logic [vdp_pkg::BYTE_W-1:0]  data_byte,
    output logic                             done,
    output logic      [vdp_pkg::BYTE_W-1:0]  read_data,
    output logic                             color_changed,
    output logic      [vdp_pkg::CIDX_W-1:0]  color_index,
    output logic                             irq_ack
);

    import vdp_pkg::*;

    localparam int VAW = $clog2(VRAM_DEPTH);
    localparam int CAW = $clog2(CRAM_DEPTH);
    localparam int RIW = $clog2(REG_COUNT);
    localparam int MW  = ADDR_W + 5;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_PAIR  = 2'd3;

    // The address is below 16 times the smallest depth, so four conditional
    // subtracts of shifted depths reduce it.
    function automatic logic [VAW-1:0] vram_index(input logic [ADDR_W-1:0] a);
        logic [MW-1:0] v;
        v = MW'(a);
        for (int k = 3; k >= 0; k--)
        begin
            if (v >= (MW'(VRAM_DEPTH) << k))
            begin
                v = v - (MW'(VRAM_DEPTH) << k);
            end
        end
        return v[VAW-1:0];
    endfunction

    function automatic logic [CAW-1:0] cram_index(input logic [CIDX_W-1:0] a);
        logic [CIDX_W:0] v;
        v = {1'b0, a};
        if (v >= (CIDX_W+1)'(CRAM_DEPTH))
        begin
            v = v - (CIDX_W+1)'(CRAM_DEPTH);
        end
        return v[CAW-1:0];
    endfunction

    logic [1:0]        state_reg, state_next;
    logic [VAW-1:0]    clr_cnt_reg;
    logic              handheld_reg;
    logic [2:0]        req_reg;
    logic [BYTE_W-1:0] data_reg;

    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              pending_reg, pending_next;
    logic [1:0]        mode_reg, mode_next;
    logic [BYTE_W-1:0] rbuf_reg, rbuf_next;
    logic [BYTE_W-1:0] latch_reg, latch_next;
    logic [BYTE_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0] video_regs_reg [REG_COUNT];
    logic [CAW-1:0]    pair_idx_reg, pair_idx_next;

    logic              done_reg, done_next;
    logic [BYTE_W-1:0] rd_reg, rd_next;
    logic              changed_reg, changed_next;
    logic [CIDX_W-1:0] cidx_reg, cidx_next;
    logic              ack_reg, ack_next;

    logic              regs_we;
    logic [RIW-1:0]    regs_idx;

    logic              vram_we;
    logic [VAW-1:0]    vram_waddr, vram_raddr;
    logic [BYTE_W-1:0] vram_wdata, vram_rdata;
    logic              cram_we;
    logic [CAW-1:0]    cram_waddr, cram_raddr;
    logic [BYTE_W-1:0] cram_wdata, cram_rdata;

    logic [ADDR_W-1:0] ctrl_addr;
    logic [CIDX_W-1:0] cram_addr;
    logic              accept;

    assign accept = start && !busy;
    assign busy   = (state_reg != S_IDLE);

    // The second control byte reads VRAM at the address it is about to set.
    assign ctrl_addr  = {data_byte[ADDR_W-9:0], addr_reg[7:0]};
    assign vram_raddr = vram_index((req_type == REQ_CTRL_WR && pending_reg) ?
                                   ctrl_addr : addr_reg);
    assign cram_addr  = addr_reg[CIDX_W-1:0] &
                        (handheld_reg ? CRAM_MASK_PAIR : CRAM_MASK_SINGLE);
    assign cram_raddr = cram_index(cram_addr);

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        pending_next  = pending_reg;
        mode_next     = mode_reg;
        rbuf_next     = rbuf_reg;
        latch_next    = latch_reg;
        status_next   = status_reg;
        pair_idx_next = pair_idx_reg;
        done_next     = 1'b0;
        rd_next       = '0;
        changed_next  = 1'b0;
        cidx_next     = '0;
        ack_next      = 1'b0;
        regs_we       = 1'b0;
        regs_idx      = data_reg[RIW-1:0];
        vram_we       = 1'b0;
        vram_waddr    = clr_cnt_reg;
        vram_wdata    = '0;
        cram_we       = 1'b0;
        cram_waddr    = clr_cnt_reg[CAW-1:0];
        cram_wdata    = '0;

        unique case (state_reg)
            S_CLEAR:
            begin
                vram_we = 1'b1;
                cram_we = (clr_cnt_reg < VAW'(CRAM_DEPTH));
                if (clr_cnt_reg == VAW'(VRAM_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                unique case (req_reg)
                    REQ_CTRL_WR:
                    begin
                        if (!pending_reg)
                        begin
                            addr_next    = {addr_reg[ADDR_W-1:8], data_reg};
                            pending_next = 1'b1;
                        end
                        else
                        begin
                            mode_next    = data_reg[7:6];
                            regs_we      = (data_reg[7:6] == MODE_REG_WR);
                            addr_next    = {data_reg[ADDR_W-9:0], addr_reg[7:0]};
                            if (data_reg[7:6] == MODE_VRAM_RD)
                            begin
                                rbuf_next = vram_rdata;
                                addr_next = {data_reg[ADDR_W-9:0], addr_reg[7:0]} + 1'b1;
                            end
                            pending_next = 1'b0;
                            ack_next     = 1'b1;
                        end
                    end
                    REQ_STATUS_RD:
                    begin
                        rd_next      = status_reg;
                        status_next  = status_reg & STATUS_KEEP_MASK;
                        pending_next = 1'b0;
                        ack_next     = 1'b1;
                    end
                    REQ_DATA_WR:
                    begin
                        rbuf_next = data_reg;
                        if (mode_reg == MODE_CRAM_WR)
                        begin
                            cram_waddr = cram_raddr;
                            cram_wdata = data_reg;
                            if (handheld_reg)
                            begin
                                if (!addr_reg[0])
                                begin
                                    latch_next = data_reg;
                                end
                                else
                                begin
                                    // The latched even byte goes to the entry below
                                    // in the following cycle.
                                    cram_we       = 1'b1;
                                    changed_next  = 1'b1;
                                    pair_idx_next = cram_index(cram_addr - 1'b1);
                                    state_next    = S_PAIR;
                                end
                            end
                            else if (cram_rdata != data_reg)
                            begin
                                cram_we      = 1'b1;
                                changed_next = 1'b1;
                            end
                            if (cram_we)
                            begin
                                cidx_next = addr_reg[CIDX_W-1:0];
                            end
                        end
                        else
                        begin
                            vram_we    = 1'b1;
                            vram_waddr = vram_index(addr_reg);
                            vram_wdata = data_reg;
                        end
                        addr_next    = addr_reg + 1'b1;
                        pending_next = 1'b0;
                    end
                    REQ_DATA_RD:
                    begin
                        rd_next      = rbuf_reg;
                        rbuf_next    = vram_rdata;
                        addr_next    = addr_reg + 1'b1;
                        pending_next = 1'b0;
                    end
                    REQ_FLAGS_SET:
                    begin
                        status_next = status_reg | data_reg;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_PAIR:
            begin
                state_next = S_IDLE;
                cram_we    = 1'b1;
                cram_waddr = pair_idx_reg;
                cram_wdata = latch_reg;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_cnt_reg  <= '0;
            handheld_reg <= 1'b0;
            addr_reg     <= '0;
            pending_reg  <= 1'b0;
            mode_reg     <= '0;
            rbuf_reg     <= '0;
            latch_reg    <= '0;
            status_reg   <= '0;
            done_reg     <= 1'b0;
            for (int i = 0; i < REG_COUNT; i++)
            begin
                video_regs_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            addr_reg    <= addr_next;
            pending_reg <= pending_next;
            mode_reg    <= mode_next;
            rbuf_reg    <= rbuf_next;
            latch_reg   <= latch_next;
            status_reg  <= status_next;
            done_reg    <= done_next;
            if (state_reg == S_CLEAR)
            begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_we)
            begin
                handheld_reg <= cfg_wdata;
            end
            if (regs_we)
            begin
                video_regs_reg[regs_idx] <= addr_reg[7:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg  <= req_type;
            data_reg <= data_byte;
        end
        pair_idx_reg <= pair_idx_next;
        rd_reg       <= rd_next;
        changed_reg  <= changed_next;
        cidx_reg     <= cidx_next;
        ack_reg      <= ack_next;
    end

    vdp_ram #(
        .DEPTH (VRAM_DEPTH),
        .WIDTH (BYTE_W)
    ) u_vram (
        .clk   (clk),
        .we    (vram_we),
        .waddr (vram_waddr),
        .wdata (vram_wdata),
        .raddr (vram_raddr),
        .rdata (vram_rdata)
    );

    vdp_ram #(
        .DEPTH (CRAM_DEPTH),
        .WIDTH (BYTE_W)
    ) u_cram (
        .clk   (clk),
        .we    (cram_we),
        .waddr (cram_waddr),
        .wdata (cram_wdata),
        .raddr (cram_raddr),
        .rdata (cram_rdata)
    );

    assign done          = done_reg;
    assign read_data     = rd_reg;
    assign color_changed = changed_reg;
    assign color_index   = cidx_reg;
    assign irq_ack       = ack_reg;

`ifndef SYNTH
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == S_EXEC))
        else $error("result strobe without an executed transaction");

    a_exec_gives_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC) |=> done)
        else $error("executed transaction produced no result strobe");

    a_vram_write_state: assert property (@(posedge clk) disable iff (!rst_n)
        vram_we |-> (state_reg == S_CLEAR || state_reg == S_EXEC))
        else $error("VRAM written outside clearing or execute");

    a_pair_after_change: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PAIR) |-> (done_next == 1'b0 && $past(changed_next)))
        else $error("paired color write without a reported change");

    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |=> !$past(accept))
        else $error("transaction accepted during clearing pass");
`endif

endmodule

`default_nettype wire

>>> tb/vdp_port_interface_checker.sv
`timescale 1ns / 1ps

module vdp_port_interface_checker (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic                        cfg_wdata,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic [2:0]                  req_type,
    input  wire logic [vdp_pkg::BYTE_W-1:0]  data_byte,
    input  wire logic                        done,
    input  wire logic [vdp_pkg::BYTE_W-1:0]  read_data,
    input  wire logic                        color_changed,
    input  wire logic [vdp_pkg::CIDX_W-1:0]  color_index,
    input  wire logic                        irq_ack,
    output int                               outstanding,
    output int                               mismatches
);

    import vdp_pkg::*;

    typedef struct packed {
        logic [BYTE_W-1:0] rd;
        logic              chg;
        logic [CIDX_W-1:0] idx;
        logic              ack;
    } port_result_t;

    // Shadow copy of the port logic and its memories.
    logic              handheld;
    logic [ADDR_W-1:0] addr;
    logic              second_pending;
    logic [1:0]        mode;
    logic [BYTE_W-1:0] rbuf;
    logic [BYTE_W-1:0] latch;
    logic [BYTE_W-1:0] status;
    logic [BYTE_W-1:0] vregs [REG_COUNT_DEF];
    logic [BYTE_W-1:0] vram_model [VRAM_DEPTH_DEF];
    logic [BYTE_W-1:0] cram_model [CRAM_DEPTH_DEF];

    port_result_t pending_results [$];
    port_result_t got_r;
    port_result_t want_r;
    port_result_t new_r;
    int           err_count = 0;

    assign mismatches = err_count;

    task automatic flag_mismatch(input string field, input logic [7:0] got,
                                 input logic [7:0] want);
        $display("%0t ns: mismatch on %s, got %0h, want %0h", $time, field, got, want);
        err_count++;
    endtask

    // Applies one transaction to the shadow state and returns the result it should give.
    task automatic apply_port_access(input logic [2:0] kind, input logic [BYTE_W-1:0] d,
                                     output port_result_t r);
        logic [BYTE_W-1:0] low;
        logic [CIDX_W-1:0] ca;
        r = '0;
        case (kind)
            REQ_CTRL_WR:
            begin
                if (!second_pending)
                begin
                    addr = {addr[ADDR_W-1:8], d};
                    second_pending = 1'b1;
                end
                else
                begin
                    low  = addr[7:0];
                    mode = d[7:6];
                    if (mode == MODE_REG_WR)
                        vregs[d[3:0]] = low;
                    addr = {d[5:0], low};
                    if (mode == MODE_VRAM_RD)
                    begin
                        rbuf = vram_model[addr];
                        addr = addr + 1'b1;
                    end
                    second_pending = 1'b0;
                    r.ack = 1'b1;
                end
            end
            REQ_STATUS_RD:
            begin
                r.rd   = status;
                status = status & STATUS_KEEP_MASK;
                second_pending = 1'b0;
                r.ack  = 1'b1;
            end
            REQ_DATA_WR:
            begin
                rbuf = d;
                if (mode == MODE_CRAM_WR)
                begin
                    ca = addr[CIDX_W-1:0] & (handheld ? CRAM_MASK_PAIR : CRAM_MASK_SINGLE);
                    if (handheld)
                    begin
                        // Even addresses only park the byte; odd ones commit the pair.
                        if (!addr[0])
                            latch = d;
                        else
                        begin
                            cram_model[ca - 1'b1] = latch;
                            cram_model[ca] = d;
                            r.chg = 1'b1;
                        end
                    end
                    else if (cram_model[ca] != d)
                    begin
                        cram_model[ca] = d;
                        r.chg = 1'b1;
                    end
                    if (r.chg)
                        r.idx = addr[CIDX_W-1:0];
                end
                else
                    vram_model[addr] = d;
                addr = addr + 1'b1;
                second_pending = 1'b0;
            end
            REQ_DATA_RD:
            begin
                r.rd = rbuf;
                rbuf = vram_model[addr];
                addr = addr + 1'b1;
                second_pending = 1'b0;
            end
            REQ_FLAGS_SET:
                status = status | d;
            default:
                ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            handheld       = 1'b0;
            addr           = '0;
            second_pending = 1'b0;
            mode           = MODE_VRAM_RD;
            rbuf           = '0;
            latch          = '0;
            status         = '0;
            for (int i = 0; i < REG_COUNT_DEF; i++)
                vregs[i] = '0;
            for (int i = 0; i < VRAM_DEPTH_DEF; i++)
                vram_model[i] = '0;
            for (int i = 0; i < CRAM_DEPTH_DEF; i++)
                cram_model[i] = '0;
            pending_results.delete();
            outstanding <= 0;
        end
        else
        begin
            // Results are retired before the transaction taken at the same edge is queued.
            if (done)
            begin
                got_r = '{read_data, color_changed, color_index, irq_ack};
                if (pending_results.size() == 0)
                    flag_mismatch("unexpected result", read_data, 8'h00);
                else
                begin
                    want_r = pending_results.pop_front();
                    if (got_r.rd !== want_r.rd)
                        flag_mismatch("read_data", got_r.rd, want_r.rd);
                    if (got_r.chg !== want_r.chg)
                        flag_mismatch("color_changed", 8'(got_r.chg), 8'(want_r.chg));
                    if (got_r.idx !== want_r.idx)
                        flag_mismatch("color_index", 8'(got_r.idx), 8'(want_r.idx));
                    if (got_r.ack !== want_r.ack)
                        flag_mismatch("irq_ack", 8'(got_r.ack), 8'(want_r.ack));
                end
            end
            if (cfg_we)
                handheld = cfg_wdata;
            if (start && !busy)
            begin
                apply_port_access(req_type, data_byte, new_r);
                pending_results.push_back(new_r);
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

>>> tb/vdp_port_interface_tb.sv
`timescale 1ns / 1ps

module vdp_port_interface_tb;

    import vdp_pkg::*;

    localparam logic [1:0] MODE_VRAM_WR     = 2'd1;
    localparam logic [2:0] REQ_RESERVED_LO  = 3'd5;
    localparam logic [2:0] REQ_RESERVED_HI  = 3'd7;
    localparam int         WATCHDOG_LIMIT   = 60000;
    localparam int         RANDOM_PHASES    = 4;
    localparam int         PHASE_ITEMS      = 470;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_we    = 1'b0;
    logic                cfg_wdata = 1'b0;
    logic                start     = 1'b0;
    logic [2:0]          req_type  = REQ_CTRL_WR;
    logic [BYTE_W-1:0]   data_byte = '0;
    logic                busy;
    logic                done;
    logic [BYTE_W-1:0]   read_data;
    logic                color_changed;
    logic [CIDX_W-1:0]   color_index;
    logic                irq_ack;
    int                  outstanding;
    int                  mismatches;
    int                  sent_items = 0;
    int                  calm_left  = 0;
    int                  idle_cycles = 0;
    int                  phase_end;

    vdp_port_interface dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .data_byte     (data_byte),
        .done          (done),
        .read_data     (read_data),
        .color_changed (color_changed),
        .color_index   (color_index),
        .irq_ack       (irq_ack)
    );

    vdp_port_interface_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .data_byte     (data_byte),
        .done          (done),
        .read_data     (read_data),
        .color_changed (color_changed),
        .color_index   (color_index),
        .irq_ack       (irq_ack),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Ends the run when neither a transaction nor a result has moved for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send_req(input logic [2:0] kind, input logic [BYTE_W-1:0] value);
        int gap;
        int r;
        if (calm_left > 0)
        begin
            calm_left--;
            gap = 0;
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                gap = 0;
            else if (r < 80)
                gap = $urandom_range(1, 3);
            else if (r < 95)
                gap = $urandom_range(4, 12);
            else if (r < 98)
                gap = $urandom_range(20, 120);
            else
            begin
                gap = 0;
                calm_left = $urandom_range(20, 60);
            end
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= kind;
        data_byte <= value;
        do @(posedge clk); while (busy);
        sent_items++;
    endtask

    task automatic point_at(input logic [ADDR_W-1:0] a, input logic [1:0] m);
        send_req(REQ_CTRL_WR, a[7:0]);
        send_req(REQ_CTRL_WR, {m, a[ADDR_W-1:8]});
    endtask

    task automatic wait_idle();
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_handheld(input logic v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Mostly a low window so that reads land on bytes written earlier.
    function automatic logic [ADDR_W-1:0] pick_addr();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return ADDR_W'($urandom_range(0, 511));
        else if (r < 8)
            return ADDR_W'($urandom);
        else
            return 14'h3ff0 + ADDR_W'($urandom_range(0, 15));
    endfunction

    // Repeated values make single-mode writes that leave the entry unchanged.
    function automatic logic [BYTE_W-1:0] pick_color();
        int r;
        r = $urandom_range(0, 3);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hff;
        else
            return 8'($urandom);
    endfunction

    task automatic random_burst();
        logic [ADDR_W-1:0] base;
        logic [1:0]        wmode;
        int                n;
        int                r;
        int                sel;
        r    = $urandom_range(0, 99);
        base = pick_addr();
        n    = $urandom_range(1, 8);
        if (r < 30)
        begin
            sel = $urandom_range(0, 2);
            wmode = (sel == 0) ? MODE_VRAM_RD : ((sel == 1) ? MODE_VRAM_WR : MODE_REG_WR);
            point_at(base, wmode);
            repeat (n) send_req(REQ_DATA_WR, 8'($urandom));
            point_at(base, MODE_VRAM_RD);
            repeat (n) send_req(REQ_DATA_RD, 8'($urandom));
        end
        else if (r < 48)
        begin
            point_at(base, MODE_CRAM_WR);
            repeat (n) send_req(REQ_DATA_WR, pick_color());
            if ($urandom_range(0, 1))
                send_req(REQ_DATA_RD, 8'($urandom));
        end
        else if (r < 60)
        begin
            point_at(base, MODE_VRAM_RD);
            repeat (n) send_req(REQ_DATA_RD, 8'($urandom));
        end
        else if (r < 70)
        begin
            send_req(REQ_FLAGS_SET, 8'($urandom));
            if ($urandom_range(0, 1))
                send_req(REQ_STATUS_RD, 8'($urandom));
        end
        else if (r < 85)
            send_req(3'($urandom_range(0, 7)), 8'($urandom));
        else if (r < 98)
        begin
            // A lone first control byte followed by something that is not its partner.
            send_req(REQ_CTRL_WR, base[7:0]);
            sel = $urandom_range(0, 3);
            case (sel)
                0: send_req(REQ_STATUS_RD, 8'($urandom));
                1: send_req(REQ_DATA_WR, 8'($urandom));
                2: send_req(REQ_DATA_RD, 8'($urandom));
                default: send_req(REQ_FLAGS_SET, 8'($urandom));
            endcase
        end
        else
            wait_idle();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        set_handheld(1'b0);

        // Status flags: read at reset, set all, read twice to see the top two clear.
        send_req(REQ_STATUS_RD, 8'h00);
        send_req(REQ_FLAGS_SET, 8'hff);
        send_req(REQ_STATUS_RD, 8'h00);
        send_req(REQ_STATUS_RD, 8'h00);
        // Write at the top address, wrap to zero, and read it back through a prefetch.
        point_at(14'h3fff, MODE_VRAM_WR);
        send_req(REQ_DATA_WR, 8'ha5);
        point_at(14'h3fff, MODE_VRAM_RD);
        send_req(REQ_DATA_RD, 8'h00);
        // A first byte cancelled by a status read, then a register write that also sets
        // the upper address bits from its second byte.
        send_req(REQ_CTRL_WR, 8'h12);
        send_req(REQ_STATUS_RD, 8'h00);
        send_req(REQ_CTRL_WR, 8'h34);
        send_req(REQ_CTRL_WR, {MODE_REG_WR, 6'h0f});
        // Single color writes: same byte, then the mask folding 0x20 onto entry 0.
        point_at(14'h001f, MODE_CRAM_WR);
        send_req(REQ_DATA_WR, 8'h00);
        send_req(REQ_DATA_WR, 8'hff);
        send_req(REQ_DATA_WR, 8'hff);
        send_req(REQ_DATA_RD, 8'h00);
        send_req(REQ_RESERVED_HI, 8'hff);
        send_req(REQ_RESERVED_LO, 8'h5a);
        wait_idle();

        set_handheld(1'b1);
        // Paired color writes: latch then commit, across the top entry, and an odd start.
        point_at(14'h003e, MODE_CRAM_WR);
        send_req(REQ_DATA_WR, 8'h11);
        send_req(REQ_DATA_WR, 8'h22);
        send_req(REQ_DATA_WR, 8'h33);
        send_req(REQ_DATA_WR, 8'h33);
        point_at(14'h0005, MODE_CRAM_WR);
        send_req(REQ_DATA_WR, 8'h00);
        wait_idle();

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            set_handheld((p % 2) == 0);
            phase_end = sent_items + PHASE_ITEMS;
            while (sent_items < phase_end)
                random_burst();
            wait_idle();
        end

        repeat (6) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
